// ----- hw/rtl/rrts_pkg.sv -----
// rrts_pkg: shared widths, request codes and types for the round-robin scheduler
// no dependencies; used by every other file of the block except rrts_mem

package rrts_pkg;

  localparam int NUM_TASKS_DEF = 8;

  localparam int REQ_W  = 2;
  localparam int TICK_W = 32;
  localparam int SP_W   = 32;
  localparam int SEL_W  = 3;
  localparam int RUN_W  = 3;
  localparam int MASK_W = 8;

  localparam logic [REQ_W-1:0] REQ_TICK   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DELAY  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SWITCH = 2'd2;
  localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd3;

  typedef struct packed {
    logic [TICK_W-1:0] sum;
    logic              eq;
  } alu_res_t;

endpackage

// ----- hw/rtl/rrts_if.sv -----
// rrts_req_if / rrts_rsp_if: valid-ready channels for requests and results
// depends on rrts_pkg for field widths

interface rrts_req_if;
  logic                       valid;
  logic                       ready;
  logic [rrts_pkg::REQ_W-1:0]  req_type;
  logic [rrts_pkg::TICK_W-1:0] delay_ticks;
  logic [rrts_pkg::SP_W-1:0]   sp_in;
  logic [rrts_pkg::SEL_W-1:0]  task_select;

  modport source (output valid, req_type, delay_ticks, sp_in, task_select, input ready);
  modport sink   (input valid, req_type, delay_ticks, sp_in, task_select, output ready);
endinterface

interface rrts_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [rrts_pkg::RUN_W-1:0]  running_task;
  logic [rrts_pkg::SP_W-1:0]   sp_out;
  logic [rrts_pkg::MASK_W-1:0] ready_mask;

  modport source (output valid, running_task, sp_out, ready_mask, input ready);
  modport sink   (input valid, running_task, sp_out, ready_mask, output ready);
endinterface

// ----- hw/rtl/rrts_mem.sv -----
// rrts_mem: one write port, one registered read port task table
// no package dependencies

module rrts_mem #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/rrts_alu.sv -----
// rrts_alu: shared 32-bit adder and equality compare for tick math and wake scan
// depends on rrts_pkg for alu_res_t

module rrts_alu (
  input  logic [rrts_pkg::TICK_W-1:0] a,
  input  logic [rrts_pkg::TICK_W-1:0] b,
  output rrts_pkg::alu_res_t          res
);

  assign res.sum = a + b;
  assign res.eq  = (a == b);

endmodule

// ----- hw/rtl/round_robin_task_scheduler_core.sv -----
// Round-robin task scheduler core. Each request gives one result. Delay and load
// requests pass the execute, read and write-back states; tick requests also scan the
// wake ticks and switch requests search for a ready task, because wake ticks are
// compared one task per cycle through a single adder/comparator and the next
// ready task is searched one candidate per cycle. A new request is taken only
// while the sequencer is idle; a finished result waits in the output register
// so the next request can be taken before it is read. Stack pointers of tasks
// never saved or loaded read back as undefined.
// depends on rrts_pkg, rrts_if, rrts_mem, rrts_alu

module round_robin_task_scheduler_core #(
  parameter int NUM_TASKS = rrts_pkg::NUM_TASKS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  rrts_req_if.sink   req_ch,
  rrts_rsp_if.source rsp_ch
);

  localparam int AW = $clog2(NUM_TASKS);
  localparam logic [AW-1:0] LAST = AW'(NUM_TASKS - 1);
  localparam logic [5:0] NT6 = 6'(NUM_TASKS);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_TICK_SCAN, S_TICK_LAST, S_SW_SCAN, S_RD, S_WB
  } state_t;

  state_t state;

  logic [rrts_pkg::REQ_W-1:0]  req;
  logic [rrts_pkg::TICK_W-1:0] delay;
  logic [rrts_pkg::SP_W-1:0]   sp;
  logic [rrts_pkg::SEL_W-1:0]  sel;

  logic [rrts_pkg::TICK_W-1:0] tick_now;
  logic [AW-1:0]               active;
  logic [NUM_TASKS-1:0]        ready;
  logic [AW-1:0]               scan_idx;
  logic [AW-1:0]               hit_idx;
  logic                        chk_valid;
  logic [AW-1:0]               cand;
  logic [AW-1:0]               cnt;

  logic [AW-1:0]               cand_next;
  logic                        sel_ok;
  logic [AW-1:0]               sel_idx;
  logic [rrts_pkg::MASK_W-1:0] mask;

  logic [rrts_pkg::TICK_W-1:0] alu_b;
  rrts_pkg::alu_res_t          alu_res;

  logic                        wake_we;
  logic [rrts_pkg::TICK_W-1:0] wake_rdata;
  logic                        sp_we;
  logic [AW-1:0]               sp_waddr;
  logic [rrts_pkg::SP_W-1:0]   sp_rdata;

  assign req_ch.ready = (state == S_IDLE) && !rst;

  assign cand_next = (cand == LAST) ? '0 : cand + AW'(1);
  assign sel_ok    = ({3'b000, sel} < NT6);
  assign sel_idx   = AW'(sel);

  for (genvar g = 0; g < rrts_pkg::MASK_W; g++) begin : g_mask
    if (g < NUM_TASKS) begin : g_on
      assign mask[g] = ready[g];
    end else begin : g_off
      assign mask[g] = 1'b0;
    end
  end

  always_comb begin
    alu_b = wake_rdata;
    if (state == S_EXEC) begin
      alu_b = (req == rrts_pkg::REQ_TICK) ? rrts_pkg::TICK_W'(1) : delay;
    end
  end

  rrts_alu u_alu (
    .a   (tick_now),
    .b   (alu_b),
    .res (alu_res)
  );

  always_comb begin
    wake_we  = (state == S_EXEC) && (req == rrts_pkg::REQ_DELAY) && (active != '0);
    sp_we    = 1'b0;
    sp_waddr = active;
    if (state == S_EXEC) begin
      if (req == rrts_pkg::REQ_SWITCH) begin
        sp_we = 1'b1;
      end else if (req == rrts_pkg::REQ_LOAD) begin
        sp_we    = sel_ok;
        sp_waddr = sel_idx;
      end
    end
  end

  rrts_mem #(.WIDTH(rrts_pkg::TICK_W), .DEPTH(NUM_TASKS)) u_wake_mem (
    .clk   (clk),
    .we    (wake_we),
    .waddr (active),
    .wdata (alu_res.sum),
    .raddr (scan_idx),
    .rdata (wake_rdata)
  );

  rrts_mem #(.WIDTH(rrts_pkg::SP_W), .DEPTH(NUM_TASKS)) u_sp_mem (
    .clk   (clk),
    .we    (sp_we),
    .waddr (sp_waddr),
    .wdata (sp),
    .raddr (active),
    .rdata (sp_rdata)
  );

  always_ff @(posedge clk) begin
    if (req_ch.valid && req_ch.ready) begin
      req   <= req_ch.req_type;
      delay <= req_ch.delay_ticks;
      sp    <= req_ch.sp_in;
      sel   <= req_ch.task_select;
    end
    if (state == S_WB && (!rsp_ch.valid || rsp_ch.ready)) begin
      rsp_ch.running_task <= rrts_pkg::RUN_W'(active);
      rsp_ch.sp_out       <= sp_rdata;
      rsp_ch.ready_mask   <= mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tick_now  <= '0;
      active    <= AW'(1);
      ready     <= '1;
      scan_idx  <= '0;
      hit_idx   <= '0;
      chk_valid <= 1'b0;
      cand      <= '0;
      cnt       <= '0;
      rsp_ch.valid <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready && state != S_WB) begin
        rsp_ch.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_ch.valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (req)
            rrts_pkg::REQ_TICK: begin
              tick_now  <= alu_res.sum;
              scan_idx  <= AW'(1);
              chk_valid <= 1'b0;
              state     <= S_TICK_SCAN;
            end
            rrts_pkg::REQ_DELAY: begin
              if (active != '0) begin
                ready[active] <= 1'b0;
              end
              state <= S_RD;
            end
            rrts_pkg::REQ_SWITCH: begin
              cand  <= active;
              cnt   <= '0;
              state <= S_SW_SCAN;
            end
            rrts_pkg::REQ_LOAD: begin
              if (sel_ok) begin
                ready[sel_idx] <= 1'b1;
              end
              state <= S_RD;
            end
            default: state <= S_RD;
          endcase
        end
        S_TICK_SCAN: begin
          if (chk_valid && alu_res.eq) begin
            ready[hit_idx] <= 1'b1;
          end
          hit_idx   <= scan_idx;
          chk_valid <= 1'b1;
          if (scan_idx == LAST) begin
            state <= S_TICK_LAST;
          end else begin
            scan_idx <= scan_idx + AW'(1);
          end
        end
        S_TICK_LAST: begin
          if (chk_valid && alu_res.eq) begin
            ready[hit_idx] <= 1'b1;
          end
          chk_valid <= 1'b0;
          state     <= S_RD;
        end
        S_SW_SCAN: begin
          if (cand_next != '0 && ready[cand_next]) begin
            active <= cand_next;
            state  <= S_RD;
          end else if (cnt == LAST) begin
            active <= '0;
            state  <= S_RD;
          end else begin
            cand <= cand_next;
            cnt  <= cnt + AW'(1);
          end
        end
        S_RD: begin
          state <= S_WB;
        end
        S_WB: begin
          if (!rsp_ch.valid || rsp_ch.ready) begin
            rsp_ch.valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/rrts_checker.sv -----
// rrts_checker: port-level assertions for the round-robin scheduler core
// depends on rrts_pkg; bound to round_robin_task_scheduler_core below

module rrts_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [rrts_pkg::RUN_W-1:0]  running_task,
  input logic [rrts_pkg::SP_W-1:0]   sp_out,
  input logic [rrts_pkg::MASK_W-1:0] ready_mask
);

  // busy after every request transfer
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while a request is in progress");

  // no result appears right after a request transfer
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too soon after request");

  // idle task is never blocked
  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ready_mask[0])
    else $error("idle task shown as blocked");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(running_task)
      && $stable(sp_out) && $stable(ready_mask))
    else $error("stalled result changed");

endmodule

bind round_robin_task_scheduler_core rrts_checker u_rrts_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (req_ch.valid),
  .in_ready     (req_ch.ready),
  .out_valid    (rsp_ch.valid),
  .out_ready    (rsp_ch.ready),
  .running_task (rsp_ch.running_task),
  .sp_out       (rsp_ch.sp_out),
  .ready_mask   (rsp_ch.ready_mask)
);

// ----- verif/round_robin_task_scheduler_core_test.sv -----
// round_robin_task_scheduler_core_test: self-checking bench for the round-robin scheduler core
// predicts every result with its own scheduler state and compares it field by field
// depends on rrts_pkg, rrts_if and round_robin_task_scheduler_core

module round_robin_task_scheduler_core_test;

  localparam int NUM_TASKS   = rrts_pkg::NUM_TASKS_DEF;
  localparam int CYCLE_LIMIT = 500000;
  localparam int LONG_HOLD   = 300;
  localparam int MAX_REPORTS = 40;

  typedef struct {
    logic [rrts_pkg::RUN_W-1:0]  run_task;
    logic [rrts_pkg::SP_W-1:0]   sp;
    logic [rrts_pkg::MASK_W-1:0] mask;
  } sched_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rrts_req_if req_bus ();
  rrts_rsp_if rsp_bus ();

  round_robin_task_scheduler_core #(.NUM_TASKS(NUM_TASKS)) uut (
    .clk    (clk),
    .rst    (rst),
    .req_ch (req_bus),
    .rsp_ch (rsp_bus)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // scheduler state as the bench sees it
  logic [rrts_pkg::TICK_W-1:0] tick_seen;
  int                          cur_task;
  logic                        task_rdy [NUM_TASKS];
  logic [rrts_pkg::TICK_W-1:0] wake_at  [NUM_TASKS];
  logic [rrts_pkg::SP_W-1:0]   stack_ptr[NUM_TASKS];

  sched_result_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  int req_calm = 0;
  int rsp_calm = 0;
  int hold_cycles_req = 0;
  int n_tick = 0, n_delay = 0, n_switch = 0, n_load = 0;
  int n_wakes = 0, n_idle_picks = 0, n_idle_delays = 0;

  function automatic void clear_schedule();
    tick_seen = '0;
    cur_task = 1;
    for (int t = 0; t < NUM_TASKS; t++) begin
      task_rdy[t] = 1'b1;
      wake_at[t] = '0;
      stack_ptr[t] = '0;
    end
  endfunction

  function automatic sched_result_t schedule_step(input logic [rrts_pkg::REQ_W-1:0] kind,
                                                  input logic [rrts_pkg::TICK_W-1:0] dly,
                                                  input logic [rrts_pkg::SP_W-1:0] sp,
                                                  input logic [rrts_pkg::SEL_W-1:0] sel);
    sched_result_t r;
    int cand;
    bit found;
    if (cur_task >= NUM_TASKS) cur_task = 0;
    case (kind)
      rrts_pkg::REQ_TICK: begin
        n_tick++;
        tick_seen = tick_seen + 32'd1;
        for (int t = 1; t < NUM_TASKS; t++) begin
          if (!task_rdy[t] && wake_at[t] == tick_seen) begin
            task_rdy[t] = 1'b1;
            n_wakes++;
          end
        end
      end
      rrts_pkg::REQ_DELAY: begin
        n_delay++;
        if (cur_task != 0) begin
          wake_at[cur_task] = tick_seen + dly;
          task_rdy[cur_task] = 1'b0;
        end else begin
          n_idle_delays++;
        end
      end
      rrts_pkg::REQ_SWITCH: begin
        n_switch++;
        stack_ptr[cur_task] = sp;
        cand = cur_task;
        found = 1'b0;
        for (int k = 0; k < NUM_TASKS && !found; k++) begin
          cand = (cand + 1) % NUM_TASKS;
          if (cand != 0 && task_rdy[cand]) found = 1'b1;
        end
        cur_task = found ? cand : 0;
        if (!found) n_idle_picks++;
      end
      default: begin
        n_load++;
        if (int'(sel) < NUM_TASKS) begin
          stack_ptr[sel] = sp;
          task_rdy[sel] = 1'b1;
        end
      end
    endcase
    r.mask = '0;
    for (int t = 0; t < NUM_TASKS && t < rrts_pkg::MASK_W; t++) r.mask[t] = task_rdy[t];
    r.run_task = cur_task[rrts_pkg::RUN_W-1:0];
    r.sp = stack_ptr[cur_task];
    return r;
  endfunction

  function automatic int pick_wait(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("mismatch at cycle %0d: %s got %h expected %h", cycles, field, got, want);
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // result check first, then prediction of the request taken at the same edge
  always @(posedge clk) begin
    sched_result_t want;
    if (!rst) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, running_task", 32'(rsp_bus.running_task), '0);
        end else begin
          want = pending_results.pop_front();
          if (rsp_bus.running_task !== want.run_task)
            report_mismatch("running_task", 32'(rsp_bus.running_task), 32'(want.run_task));
          if (rsp_bus.sp_out !== want.sp)
            report_mismatch("sp_out", rsp_bus.sp_out, want.sp);
          if (rsp_bus.ready_mask !== want.mask)
            report_mismatch("ready_mask", 32'(rsp_bus.ready_mask), 32'(want.mask));
        end
      end
      if (req_bus.valid && req_bus.ready)
        pending_results.push_back(schedule_step(req_bus.req_type, req_bus.delay_ticks,
                                                req_bus.sp_in, req_bus.task_select));
    end
  end

  // result side: one wait per transfer, plus a long hold when asked
  initial begin : result_side
    int n;
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      n = pick_wait(rsp_calm) + hold_cycles_req;
      hold_cycles_req = 0;
      if (n > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      rsp_bus.ready <= 1'b1;
      do @(posedge clk); while (!rsp_bus.valid);
    end
  end

  task automatic send_request(input logic [rrts_pkg::REQ_W-1:0] kind,
                              input logic [rrts_pkg::TICK_W-1:0] dly,
                              input logic [rrts_pkg::SP_W-1:0] sp,
                              input logic [rrts_pkg::SEL_W-1:0] sel);
    int gap;
    gap = pick_wait(req_calm);
    @(negedge clk);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_bus.valid       <= 1'b1;
    req_bus.req_type    <= kind;
    req_bus.delay_ticks <= dly;
    req_bus.sp_in       <= sp;
    req_bus.task_select <= sel;
    do @(posedge clk); while (!req_bus.ready);
    @(negedge clk);
    req_bus.valid <= 1'b0;
  endtask

  task automatic wait_all_results();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // task 1 first so no result ever reads a stack pointer that was never written
  task automatic load_all_tasks();
    logic [rrts_pkg::SP_W-1:0] sps[NUM_TASKS];
    sps = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
            32'h2000_1000, 32'h2000_2000, 32'h8000_0001, 32'h7FFF_FFFE};
    send_request(rrts_pkg::REQ_LOAD, '0, sps[1], 3'd1);
    for (int t = 0; t < NUM_TASKS; t++)
      if (t != 1)
        send_request(rrts_pkg::REQ_LOAD, 32'hFFFF_FFFF, sps[t], t[rrts_pkg::SEL_W-1:0]);
  endtask

  // delay each user task in turn, then switch; the last switch lands on idle
  task automatic block_all_tasks();
    logic [rrts_pkg::TICK_W-1:0] dlys[7];
    dlys = '{32'd2, 32'hFFFF_FFFF, 32'd0, 32'd3, 32'd1, 32'd5, 32'd4};
    for (int k = 0; k < 7; k++) begin
      send_request(rrts_pkg::REQ_DELAY, dlys[k], $urandom, 3'd7);
      send_request(rrts_pkg::REQ_SWITCH, '0, (k % 2) ? 32'hFFFF_FFFF : 32'h0000_0000, 3'd0);
    end
  endtask

  task automatic wake_from_idle();
    send_request(rrts_pkg::REQ_DELAY, 32'h8000_0000, $urandom, 3'd0);
    send_request(rrts_pkg::REQ_TICK, $urandom, $urandom, 3'd5);
    send_request(rrts_pkg::REQ_SWITCH, '0, 32'h1234_5678, 3'd2);
  endtask

  task automatic random_traffic(input int count);
    logic [rrts_pkg::REQ_W-1:0]  kind;
    logic [rrts_pkg::TICK_W-1:0] dly;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      kind = (r < 35) ? rrts_pkg::REQ_TICK :
             (r < 55) ? rrts_pkg::REQ_DELAY :
             (r < 85) ? rrts_pkg::REQ_SWITCH : rrts_pkg::REQ_LOAD;
      r = $urandom_range(0, 99);
      if (r < 70)      dly = $urandom_range(1, 6);
      else if (r < 78) dly = '0;
      else if (r < 90) dly = $urandom;
      else             dly = 32'hFFFF_FFFF - $urandom_range(0, 3);
      send_request(kind, dly, $urandom, rrts_pkg::SEL_W'($urandom_range(0, NUM_TASKS - 1)));
    end
  endtask

  // the core holds back its results and stops taking requests while the result side holds off
  task automatic receiver_hold_off();
    int saved_calm;
    hold_cycles_req = LONG_HOLD;
    saved_calm = req_calm;
    req_calm = 24;
    random_traffic(24);
    req_calm = saved_calm;
  endtask

  task automatic drain_and_resume();
    wait_all_results();
    random_traffic(10);
  endtask

  initial begin
    req_bus.valid       = 1'b0;
    req_bus.req_type    = rrts_pkg::REQ_TICK;
    req_bus.delay_ticks = '0;
    req_bus.sp_in       = '0;
    req_bus.task_select = '0;
    clear_schedule();
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    load_all_tasks();
    block_all_tasks();
    wake_from_idle();
    random_traffic(600);
    receiver_hold_off();
    drain_and_resume();
    random_traffic(740);

    @(negedge clk);
    req_bus.valid <= 1'b0;
    wait_all_results();
    repeat (3 * NUM_TASKS + 20) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", 32'(pending_results.size()), '0);

    $display("requests: %0d tick, %0d delay (%0d while idle), %0d switch, %0d load",
             n_tick, n_delay, n_idle_delays, n_switch, n_load);
    $display("scheduling: %0d timed wake-ups, %0d fallbacks to idle, %0d mismatches",
             n_wakes, n_idle_picks, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/rrts_pkg.sv
hw/rtl/rrts_if.sv
hw/rtl/rrts_mem.sv
hw/rtl/rrts_alu.sv
hw/rtl/round_robin_task_scheduler_core.sv
hw/rtl/rrts_checker.sv
verif/round_robin_task_scheduler_core_test.sv
